### rtl/mpq_pkg.sv
// Shared types, codes and defaults for the min priority queue.
package mpq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

### rtl/mpq_cell.sv
// One storage cell of the sorted chain: holds a value, shifts toward a neighbor.
module mpq_cell #(
    parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                          i_clk,
    input  mpq_pkg::t_cell_ctl            i_ctl,
    input  logic        [CNT_W-1:0]       i_count,
    input  logic signed [VALUE_WIDTH-1:0] i_new_value,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                          i_prev_keep,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_keep
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          live;

    assign live    = CNT_W'(INDEX) < i_count;
    // Equal values stay ahead of the newcomer so arrival order is kept.
    assign o_keep  = live && (r_value <= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_value = i_prev_keep ? i_new_value : i_prev_value;
            end
        end else if (i_ctl.rem) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### rtl/min_priority_queue.sv
// Top level of the min priority queue: cell chain, fill count and result registers.
// A bounded queue of signed values kept sorted in a chain of CAPACITY cells.
// Each request is either an insert or a remove-minimum:
// every cell compares its value with the new one in parallel and keeps it,
// takes the new value or takes its left neighbor's value, and a remove shifts
// the whole chain one place toward the head. busy stays low, so a request may
// be issued in every cycle; its result appears on the output ports with
// o_strobe one cycle after acceptance and must be taken in that cycle. Equal
// values keep their arrival order, so the earliest of equal minima leaves first.
module min_priority_queue #(
    parameter int CAPACITY    = mpq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic signed [mpq_pkg::DATA_W-1:0]   i_value,
    output logic                                o_strobe,
    output logic signed [mpq_pkg::DATA_W-1:0]   o_removed_value,
    output logic        [mpq_pkg::STATUS_W-1:0] o_status,
    output logic        [mpq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    logic                                r_strobe;
    logic signed [mpq_pkg::DATA_W-1:0]   r_removed;
    logic        [mpq_pkg::STATUS_W-1:0] r_status;
    logic        [mpq_pkg::OCC_W-1:0]    r_occ;
    logic signed [mpq_pkg::DATA_W-1:0]   n_removed;
    logic        [mpq_pkg::STATUS_W-1:0] n_status;

    mpq_pkg::t_cell_ctl            ctl;
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic                          cell_keep  [CAPACITY];
    logic                          is_full;
    logic                          is_empty;

    assign busy      = 1'b0;
    assign new_value = VALUE_WIDTH'(i_value);
    assign is_full   = r_count == CNT_W'(CAPACITY);
    assign is_empty  = r_count == '0;

    always_comb begin
        ctl.ins   = start && (mpq_pkg::t_op'(i_operation) == mpq_pkg::OP_INSERT) && !is_full;
        ctl.rem   = start && (mpq_pkg::t_op'(i_operation) == mpq_pkg::OP_REMOVE) && !is_empty;
        n_count   = r_count;
        n_removed = '0;
        n_status  = mpq_pkg::ST_OK;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count   = r_count - CNT_W'(1);
            // Head of the chain holds the minimum.
            n_removed = mpq_pkg::DATA_W'(cell_value[0]);
        end else if (mpq_pkg::t_op'(i_operation) == mpq_pkg::OP_INSERT) begin
            n_status = mpq_pkg::ST_FULL;
        end else begin
            n_status = mpq_pkg::ST_EMPTY;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] prev_value;
        logic signed [VALUE_WIDTH-1:0] next_value;
        logic                          prev_keep;

        if (g == 0) begin : g_head
            assign prev_value = new_value;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
            assign prev_keep  = cell_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[g];
        end else begin : g_inner
            assign next_value = cell_value[g+1];
        end

        mpq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_new_value  (new_value),
            .i_prev_value (prev_value),
            .i_prev_keep  (prev_keep),
            .i_next_value (next_value),
            .o_value      (cell_value[g]),
            .o_keep       (cell_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (start) begin
                r_count <= n_count;
            end
            r_strobe <= start;
        end
        if (start) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= mpq_pkg::OCC_W'(n_count);
        end
    end

    assign o_strobe        = r_strobe;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_occupancy     = r_occ;

endmodule

### rtl/mpq_checker.sv
// Port-level checks for the min priority queue, bound to the top level.
module mpq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_strobe,
    input logic signed [mpq_pkg::DATA_W-1:0]   o_removed_value,
    input logic        [mpq_pkg::STATUS_W-1:0] o_status,
    input logic        [mpq_pkg::OCC_W-1:0]    o_occupancy
);

    // Every accepted request yields its result in the next cycle.
    a_req_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("accepted request produced no result");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without a request");

    a_empty_occ : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == mpq_pkg::ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty error with nonzero occupancy");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != mpq_pkg::ST_OK) |-> (o_removed_value == '0))
        else $error("error result carries a value");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_removed_value (o_removed_value),
    .o_status        (o_status),
    .o_occupancy     (o_occupancy)
);

### sim/tb.sv
// Self-checking testbench for the min priority queue: directed table, then random bursts.
module tb;
    import mpq_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int STALL_LIMIT = 500;
    localparam int PHASE_ITEMS = 450;

    typedef struct packed {
        logic signed [DATA_W-1:0]   removed;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occupancy;
    } t_outcome;

    typedef struct {
        t_op                op;
        logic [DATA_W-1:0]  value;
        bit                 pinned;
        t_outcome           want;
    } t_directed_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_operation;
    logic signed [DATA_W-1:0]    i_value;
    logic                        o_strobe;
    logic signed [DATA_W-1:0]    o_removed_value;
    logic        [STATUS_W-1:0]  o_status;
    logic        [OCC_W-1:0]     o_occupancy;

    // Typed expectation that travels with the request currently driven
    logic     pin_valid;
    t_outcome pin_want;

    logic signed [DATA_W-1:0] held_values[$];
    t_outcome                 pending_outcomes[$];

    int failures;
    int results_checked;
    int n_insert, n_remove, n_full, n_empty, peak_fill;
    int idle_cycles;
    bit progress;
    t_outcome got, predicted;

    t_directed_row directed_rows [0:23] = '{
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'sd0, ST_OK, 5'd1}},
        '{OP_INSERT, 32'h8000_0000, 1'b1, '{32'sd0, ST_OK, 5'd2}},
        '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'sh8000_0000, ST_OK, 5'd1}},
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, ST_OK, 5'd0}},
        '{OP_REMOVE, 32'h5A5A_5A5A, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
        '{OP_INSERT, 32'd5,         1'b0, '0},
        '{OP_INSERT, -32'd3,        1'b0, '0},
        '{OP_INSERT, 32'd5,         1'b0, '0},
        '{OP_INSERT, 32'd0,         1'b0, '0},
        '{OP_INSERT, -32'd1,        1'b0, '0},
        '{OP_INSERT, -32'd3,        1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
        '{OP_INSERT, 32'd1,         1'b0, '0},
        '{OP_INSERT, -32'd2,        1'b0, '0},
        '{OP_INSERT, 32'd0,         1'b0, '0},
        '{OP_INSERT, 32'h1234_5678, 1'b0, '0},
        '{OP_INSERT, -32'd3,        1'b0, '0},
        '{OP_INSERT, 32'hFFFF_0000, 1'b0, '0},
        '{OP_INSERT, 32'd2,         1'b0, '0},
        '{OP_INSERT, 32'hA5A5_A5A5, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0}
    };

    min_priority_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow queue and return the outcome it should produce.
    function automatic t_outcome apply_request(input t_op op,
                                               input logic signed [DATA_W-1:0] val);
        t_outcome r;
        int best;
        r = '0;
        if (op == OP_INSERT) begin
            if (held_values.size() >= CAPACITY)
                r.status = ST_FULL;
            else
                held_values.push_back(val);
        end else if (held_values.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            best = 0;
            // Strict compare keeps the earliest of equal minima
            for (int i = 1; i < held_values.size(); i++)
                if (held_values[i] < held_values[best])
                    best = i;
            r.removed = held_values[best];
            held_values.delete(best);
        end
        r.occupancy = OCC_W'(held_values.size());
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 8: return $urandom;
            4, 5, 6:       return $urandom_range(0, 15) - 8;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Hold the request until accepted, then optionally go quiet for a random stretch.
    task automatic issue_request(input t_op op, input logic [DATA_W-1:0] val,
                                 input bit pinned, input t_outcome want, input int idle_pct);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        pin_valid   <= pinned;
        pin_want    <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start     <= 1'b0;
            pin_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            progress = 1'b0;
            // Check the result first: it belongs to a request accepted earlier
            if (o_strobe) begin
                progress = 1'b1;
                got.removed   = o_removed_value;
                got.status    = o_status;
                got.occupancy = o_occupancy;
                if (pending_outcomes.size() == 0) begin
                    if (failures < 10)
                        $display("ERROR: unexpected result removed=%0d status=%0d occ=%0d",
                                 got.removed, got.status, got.occupancy);
                    failures++;
                end else begin
                    predicted = pending_outcomes.pop_front();
                    results_checked++;
                    if (got !== predicted) begin
                        if (failures < 10) begin
                            $write("ERROR: result %0d expected removed=%0d status=%0d ",
                                   results_checked, predicted.removed, predicted.status);
                            $display("occ=%0d, got removed=%0d status=%0d occ=%0d",
                                     predicted.occupancy, got.removed, got.status,
                                     got.occupancy);
                        end
                        failures++;
                    end
                end
            end
            if (start && !busy) begin
                progress  = 1'b1;
                predicted = apply_request(t_op'(i_operation), i_value);
                pending_outcomes.push_back(pin_valid ? pin_want : predicted);
                if (t_op'(i_operation) == OP_INSERT) n_insert++;
                else n_remove++;
                if (predicted.status == ST_FULL) n_full++;
                if (predicted.status == ST_EMPTY) n_empty++;
                if (held_values.size() > peak_fill) peak_fill = held_values.size();
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int phase_idle [0:2];
        int ins_pct [0:2];
        int left, blk, mode;
        bit quiet;
        t_op op;

        phase_idle = '{0, 72, 28};
        ins_pct    = '{80, 50, 20};
        failures = 0; results_checked = 0;
        n_insert = 0; n_remove = 0; n_full = 0; n_empty = 0; peak_fill = 0;
        start       <= 1'b0;
        i_operation <= OP_INSERT;
        i_value     <= '0;
        pin_valid   <= 1'b0;
        pin_want    <= '0;
        i_rst_n     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            issue_request(directed_rows[r].op, directed_rows[r].value,
                          directed_rows[r].pinned, directed_rows[r].want, 0);

        // Bursts lean to insert, remove or neither so the queue swings between full and empty
        for (int phase = 0; phase < 3; phase++) begin
            left = PHASE_ITEMS;
            while (left > 0) begin
                blk   = $urandom_range(10, 50);
                mode  = $urandom_range(0, 2);
                quiet = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < blk && left > 0; k++) begin
                    op = ($urandom_range(0, 99) < ins_pct[mode]) ? OP_INSERT : OP_REMOVE;
                    issue_request(op, draw_value(), 1'b0, '0,
                                  quiet ? 0 : phase_idle[phase]);
                    left--;
                end
            end
        end
        start     <= 1'b0;
        pin_valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $display("ERROR: %0d results never arrived", pending_outcomes.size());
            failures++;
        end

        $display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d on empty).",
                 n_insert, n_full, n_remove, n_empty);
        $display("Checked %0d results, peak fill %0d of %0d, %0d mismatches.",
                 results_checked, peak_fill, CAPACITY, failures);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
